// ===== rtl/core/phong_tessellation_point_core_macros.svh =====
// Assertion macros shared by the tessellation point core.
`ifndef PHONG_TESSELLATION_POINT_CORE_MACROS_SVH
`define PHONG_TESSELLATION_POINT_CORE_MACROS_SVH
// Assert a property on every clock edge outside reset.
`define PTP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Assert an implication on every clock edge outside reset.
`define PTP_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);
`endif

// ===== rtl/core/ptp_pkg.sv =====
// Package: widths, sequencer states and saturation helpers for the tessellation core.
package ptp_pkg;
  localparam int PosW = 32;
  localparam int NrmW = 16;
  localparam int WgtW = 17;
  localparam int ProdW = PosW + WgtW;
  localparam int AccW = ProdW + 2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BLEND, ST_DIFF, ST_DOT, ST_PROJ, ST_FINAL, ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    SH_15, SH_14
  } shift_e;

  typedef struct packed {
    logic signed [PosW-1:0] a;
    logic signed [WgtW-1:0] b;
    shift_e                 sh;
  } mul_req_t;

  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'((64'sd1 <<< (PosW - 1)) - 64'sd1);
    lo = -hi - AccW'(1);
    if (x > hi) return hi[PosW-1:0];
    if (x < lo) return lo[PosW-1:0];
    return x[PosW-1:0];
  endfunction
endpackage

// ===== rtl/core/phong_tessellation_point_core.sv =====
// Top level: phong tessellation point evaluator around one shared multiplier.
// Load item: stored at the accepting edge, busy_o stays low, no result; while idle, one load
// per cycle. Evaluate item: 36 multiplies issued one per cycle, with a stall wherever a step
// needs the group before it; done_o strobes as the last final-blend result is written out.
// busy_o drops with the strobe, so one evaluate runs at a time; the receiver cannot stall.
// rst_ni (async, active low) clears the corner store, the sequencer and the accumulator.
module phong_tessellation_point_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                op_i,
  input  logic [1:0]          corner_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic signed [15:0]  nrm_x_i,
  input  logic signed [15:0]  nrm_y_i,
  input  logic signed [15:0]  nrm_z_i,
  input  logic [15:0]         weight_u_i,
  input  logic [15:0]         weight_v_i,
  output logic                done_o,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic signed [31:0]  out_z_o
);
`include "phong_tessellation_point_core_macros.svh"

  localparam int PW = ptp_pkg::PosW;
  localparam int NW = ptp_pkg::NrmW;
  localparam int AW = ptp_pkg::AccW;
  localparam int WW = ptp_pkg::WgtW;

  // corner store, reset to zero
  logic signed [PW-1:0] pos_q [9];
  logic signed [NW-1:0] nrm_q [9];

  logic signed [WW-1:0] wu_q, wv_q, ww_q;
  logic signed [PW-1:0] b_q [3];      // flat point
  logic signed [PW-1:0] d_q [3];      // flat point minus current corner
  logic signed [PW-1:0] dot_q;
  logic signed [PW-1:0] proj_q [9];   // projections, corner-major
  logic signed [PW-1:0] out_q [3];
  logic signed [AW-1:0] acc_q;

  ptp_pkg::state_e state_q, state_d;
  logic [1:0] ax_q, ax_d;    // axis
  logic [1:0] cn_q, cn_d;    // corner
  logic [1:0] tm_q, tm_d;    // term within a group
  logic       done_q;

  // a multiply issued this cycle, and whether it closes its group
  logic issue;
  logic last;

  // tag of the multiply in flight; its result shows on mres in the cycle after issue
  logic            tv_q;
  ptp_pkg::state_e tk_q;
  logic [1:0]      tax_q;
  logic [1:0]      tcn_q;
  logic            tlast_q;

  ptp_pkg::mul_req_t    req;
  logic signed [AW-1:0] mres;

  ptp_mul u_mul (.clk_i(clk_i), .req_i(req), .res_o(mres));

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ptp_pkg::ST_IDLE);

  // weight select for a blend term
  function automatic logic signed [WW-1:0] wsel(input logic [1:0] t,
      input logic signed [WW-1:0] u, input logic signed [WW-1:0] v,
      input logic signed [WW-1:0] w);
    case (t)
      2'd0:    return u;
      2'd1:    return v;
      default: return w;
    endcase
  endfunction

  // store indexes: term-major for blends, corner-major for dot and projection
  logic [3:0] tm_idx, cn_ax_idx, cn_tm_idx, ld_idx;
  assign tm_idx    = 4'(tm_q) * 4'd3 + 4'(ax_q);
  assign cn_ax_idx = 4'(cn_q) * 4'd3 + 4'(ax_q);
  assign cn_tm_idx = 4'(cn_q) * 4'd3 + 4'(tm_q);
  assign ld_idx    = 4'(corner_i) * 4'd3;

  // Sequencer: issue one multiply per cycle; hold the first issue of the final
  // blend or projection while the previous group's last result is still landing.
  always_comb begin
    state_d = state_q;
    ax_d    = ax_q;
    cn_d    = cn_q;
    tm_d    = tm_q;
    issue   = 1'b0;
    last    = 1'b0;
    req.a   = '0;
    req.b   = '0;
    req.sh  = ptp_pkg::SH_15;
    unique case (state_q) inside
      ptp_pkg::ST_IDLE: begin
        ax_d = '0;
        cn_d = '0;
        tm_d = '0;
        if (accept && op_i) state_d = ptp_pkg::ST_BLEND;
      end
      ptp_pkg::ST_BLEND, ptp_pkg::ST_FINAL: begin
        // final blend needs every projection written
        if (!(tv_q && ax_q == 2'd0 && tm_q == 2'd0)) begin
          issue = 1'b1;
          last  = (tm_q == 2'd2);
          req.b = wsel(tm_q, wu_q, wv_q, ww_q);
          if (state_q == ptp_pkg::ST_BLEND) begin
            req.a = pos_q[tm_idx];
          end else begin
            req.a = proj_q[tm_idx];
          end
          if (tm_q == 2'd2) begin
            tm_d = '0;
            if (ax_q == 2'd2) begin
              ax_d = '0;
              if (state_q == ptp_pkg::ST_BLEND) begin
                state_d = ptp_pkg::ST_DIFF;
              end else begin
                state_d = ptp_pkg::ST_DONE;
              end
            end else begin
              ax_d = ax_q + 2'd1;
            end
          end else begin
            tm_d = tm_q + 2'd1;
          end
        end
      end
      ptp_pkg::ST_DIFF: begin
        // wait for the flat point to settle, then form the differences
        if (!tv_q) state_d = ptp_pkg::ST_DOT;
      end
      ptp_pkg::ST_DOT: begin
        issue  = 1'b1;
        last   = (tm_q == 2'd2);
        req.a  = d_q[tm_q];
        req.b  = WW'(nrm_q[cn_tm_idx]);
        req.sh = ptp_pkg::SH_14;
        if (tm_q == 2'd2) begin
          tm_d    = '0;
          state_d = ptp_pkg::ST_PROJ;
        end else begin
          tm_d = tm_q + 2'd1;
        end
      end
      ptp_pkg::ST_PROJ: begin
        // hold the first axis until the dot product is written
        if (!(tv_q && ax_q == 2'd0)) begin
          issue  = 1'b1;
          last   = 1'b1;
          req.a  = dot_q;
          req.b  = WW'(nrm_q[cn_ax_idx]);
          req.sh = ptp_pkg::SH_14;
          if (ax_q == 2'd2) begin
            ax_d = '0;
            if (cn_q == 2'd2) begin
              cn_d    = '0;
              state_d = ptp_pkg::ST_FINAL;
            end else begin
              cn_d    = cn_q + 2'd1;
              state_d = ptp_pkg::ST_DIFF;
            end
          end else begin
            ax_d = ax_q + 2'd1;
          end
        end
      end
      ptp_pkg::ST_DONE:  state_d = ptp_pkg::ST_IDLE;
      default:           state_d = ptp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptp_pkg::ST_IDLE;
      ax_q    <= '0;
      cn_q    <= '0;
      tm_q    <= '0;
      tv_q    <= 1'b0;
      tk_q    <= ptp_pkg::ST_IDLE;
      tax_q   <= '0;
      tcn_q   <= '0;
      tlast_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
      cn_q    <= cn_d;
      tm_q    <= tm_d;
      tv_q    <= issue;
      tk_q    <= state_q;
      tax_q   <= ax_q;
      tcn_q   <= cn_q;
      tlast_q <= last;
      // the last final-blend result lands in the done cycle
      done_q  <= (state_q == ptp_pkg::ST_DONE);
    end
  end

  // corner store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        pos_q[i] <= '0;
        nrm_q[i] <= '0;
      end
    end else if (accept && !op_i && corner_i != 2'd3) begin
      pos_q[ld_idx + 4'd0] <= ptp_pkg::sat_pos(AW'(pos_x_i));
      pos_q[ld_idx + 4'd1] <= ptp_pkg::sat_pos(AW'(pos_y_i));
      pos_q[ld_idx + 4'd2] <= ptp_pkg::sat_pos(AW'(pos_z_i));
      nrm_q[ld_idx + 4'd0] <= nrm_x_i;
      nrm_q[ld_idx + 4'd1] <= nrm_y_i;
      nrm_q[ld_idx + 4'd2] <= nrm_z_i;
    end
  end

  logic [16:0] wu_c, wv_c;
  always_comb begin
    wu_c = (weight_u_i > 16'd32768) ? 17'd32768 : {1'b0, weight_u_i};
    wv_c = (weight_v_i > 16'd32768) ? 17'd32768 : {1'b0, weight_v_i};
  end

  // accumulate a group's terms; drop the sum once the group closes
  logic signed [AW-1:0] acc_n;
  assign acc_n = acc_q + mres;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (tv_q && tk_q != ptp_pkg::ST_PROJ) begin
      acc_q <= tlast_q ? '0 : acc_n;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept && op_i) begin
      wu_q <= signed'(wu_c);
      wv_q <= signed'(wv_c);
      ww_q <= WW'(17'sd32768 - signed'(wu_c) - signed'(wv_c));
    end
    if (state_q == ptp_pkg::ST_DIFF && !tv_q) begin
      for (int a = 0; a < 3; a++) begin
        d_q[2'(a)] <= ptp_pkg::sat_pos(AW'(b_q[2'(a)]) -
                                       AW'(pos_q[4'(cn_q) * 4'd3 + 4'(a)]));
      end
    end
    // write back the result that closes a group
    if (tv_q && tlast_q) begin
      case (tk_q)
        ptp_pkg::ST_BLEND: b_q[tax_q] <= ptp_pkg::sat_pos(acc_n);
        ptp_pkg::ST_DOT:   dot_q <= ptp_pkg::sat_pos(acc_n);
        ptp_pkg::ST_PROJ:  proj_q[4'(tcn_q) * 4'd3 + 4'(tax_q)] <=
                             ptp_pkg::sat_pos(AW'(b_q[tax_q]) - mres);
        ptp_pkg::ST_FINAL: out_q[tax_q] <= ptp_pkg::sat_pos(acc_n);
        default: ;
      endcase
    end
  end

  assign done_o  = done_q;
  assign out_x_o = out_q[0];
  assign out_y_o = out_q[1];
  assign out_z_o = out_q[2];

  `PTP_ASSERT_IMP(a_done_pulse, clk_i, rst_ni, done_o, !$past(done_o), "done strobe longer than one cycle")
  `PTP_ASSERT_IMP(a_busy_done, clk_i, rst_ni, done_o, !busy_o, "done while still busy")
  `PTP_ASSERT_IMP(a_load_nobusy, clk_i, rst_ni, start_i && !busy_o && !op_i, ##1 !busy_o, "load made block busy")
  `PTP_ASSERT(a_idle_no_tag, clk_i, rst_ni, busy_o || !tv_q, "multiplier result while idle")
endmodule

// ===== rtl/core/ptp_mul.sv =====
// Shared multiplier with round-half-up shift, one registered result per cycle.
module ptp_mul (
  input  logic                                   clk_i,
  input  ptp_pkg::mul_req_t                      req_i,
  output logic signed [ptp_pkg::AccW-1:0]        res_o
);
  logic signed [ptp_pkg::ProdW-1:0] prod;
  logic signed [ptp_pkg::AccW-1:0]  res_d, res_q;

  always_comb begin
    prod = ptp_pkg::ProdW'(req_i.a * req_i.b);
    // round half up, floor shift
    if (req_i.sh == ptp_pkg::SH_15) begin
      res_d = (ptp_pkg::AccW'(prod) + ptp_pkg::AccW'(1 <<< 14)) >>> 15;
    end else begin
      res_d = (ptp_pkg::AccW'(prod) + ptp_pkg::AccW'(1 <<< 13)) >>> 14;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the phong tessellation point core: directed table, then random loads and evaluates.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;
  localparam int   PW = 32;   // width of stored positions and intermediates

  typedef struct {
    logic        op;
    logic [1:0]  corner;
    logic [31:0] px, py, pz;
    logic [15:0] nx, ny, nz;
    logic [15:0] wu, wv;
    bit          has_lit;   // expected result typed in the table row
    logic [31:0] ex, ey, ez;
  } item_t;

  typedef struct {
    logic [31:0] x, y, z;
  } point_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        op_i = 1'b0;
  logic [1:0]  corner_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [15:0] nrm_x_i = '0, nrm_y_i = '0, nrm_z_i = '0;
  logic [15:0] weight_u_i = '0, weight_v_i = '0;
  logic        busy_o, done_o;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;

  phong_tessellation_point_core uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .corner_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .nrm_x_i, .nrm_y_i, .nrm_z_i,
    .weight_u_i, .weight_v_i, .done_o, .out_x_o, .out_y_o, .out_z_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor's own copy of the patch corners.
  longint patch_pos[9];
  longint patch_nrm[9];
  point_t expected_points[$];
  int     fail_count = 0;

  function automatic longint clamp_bits(longint x, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  // Round half up, then floor shift (arithmetic shift floors).
  function automatic longint round_shift(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint weigh3(longint a, longint b, longint c,
                                    longint wu, longint wv, longint ww);
    return clamp_bits(round_shift(a * wu, 15) + round_shift(b * wv, 15)
                      + round_shift(c * ww, 15), PW);
  endfunction

  // Apply one item to the corner copy; return 1 with the point for an evaluate.
  function automatic bit tessellate(input item_t it, output point_t pt);
    longint wu, wv, ww, dot, d;
    longint flat[3];
    longint proj[3][3];
    longint r[3];
    if (it.op == OP_LOAD) begin
      if (it.corner > 2) return 1'b0;   // corner three: drop the load
      patch_pos[it.corner*3]   = clamp_bits(longint'($signed(it.px)), PW);
      patch_pos[it.corner*3+1] = clamp_bits(longint'($signed(it.py)), PW);
      patch_pos[it.corner*3+2] = clamp_bits(longint'($signed(it.pz)), PW);
      patch_nrm[it.corner*3]   = longint'($signed(it.nx));
      patch_nrm[it.corner*3+1] = longint'($signed(it.ny));
      patch_nrm[it.corner*3+2] = longint'($signed(it.nz));
      return 1'b0;
    end
    wu = (it.wu > 32768) ? 32768 : it.wu;
    wv = (it.wv > 32768) ? 32768 : it.wv;
    ww = 32768 - wu - wv;
    for (int a = 0; a < 3; a++)
      flat[a] = weigh3(patch_pos[a], patch_pos[3+a], patch_pos[6+a], wu, wv, ww);
    for (int c = 0; c < 3; c++) begin
      dot = 0;
      for (int a = 0; a < 3; a++) begin
        d = clamp_bits(flat[a] - patch_pos[c*3+a], PW);
        dot += round_shift(d * patch_nrm[c*3+a], 14);
      end
      dot = clamp_bits(dot, PW);
      for (int a = 0; a < 3; a++)
        proj[c][a] = clamp_bits(flat[a] - round_shift(dot * patch_nrm[c*3+a], 14), PW);
    end
    for (int a = 0; a < 3; a++)
      r[a] = clamp_bits(weigh3(proj[0][a], proj[1][a], proj[2][a], wu, wv, ww), 32);
    pt.x = r[0][31:0];
    pt.y = r[1][31:0];
    pt.z = r[2][31:0];
    return 1'b1;
  endfunction

  // Check each strobed result against the oldest expected point.
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && done_o) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result %h %h %h", $time, out_x_o, out_y_o, out_z_o);
        fail_count++;
      end else begin
        want = expected_points.pop_front();
        if (out_x_o !== want.x) begin
          $display("%0t: out_x expected %h actual %h", $time, want.x, out_x_o);
          fail_count++;
        end
        if (out_y_o !== want.y) begin
          $display("%0t: out_y expected %h actual %h", $time, want.y, out_y_o);
          fail_count++;
        end
        if (out_z_o !== want.z) begin
          $display("%0t: out_z expected %h actual %h", $time, want.z, out_z_o);
          fail_count++;
        end
      end
    end
  end

  function automatic item_t load_item(logic [1:0] k, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z, logic [15:0] nx, logic [15:0] ny,
                                      logic [15:0] nz);
    item_t it;
    it = '{default: '0};
    it.op = OP_LOAD;
    it.corner = k;
    it.px = x; it.py = y; it.pz = z;
    it.nx = nx; it.ny = ny; it.nz = nz;
    it.wu = 16'($urandom); it.wv = 16'($urandom);   // unused by a load
    return it;
  endfunction

  function automatic item_t eval_item(logic [15:0] u, logic [15:0] v);
    item_t it;
    it = '{default: '0};
    it.op = OP_EVAL;
    it.corner = 2'($urandom);              // unused by an evaluate
    it.px = $urandom; it.py = $urandom; it.pz = $urandom;
    it.nx = 16'($urandom); it.ny = 16'($urandom); it.nz = 16'($urandom);
    it.wu = u; it.wv = v;
    return it;
  endfunction

  function automatic item_t lit(item_t it, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    it.has_lit = 1'b1;
    it.ex = x; it.ey = y; it.ez = z;
    return it;
  endfunction

  function automatic logic [15:0] rand_normal();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic [31:0] rand_position();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(255)
                                  : 32'h8000_0000 + $urandom_range(255);
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(7))
      0: return 16'($urandom);             // anything, often above one
      1: return $urandom_range(1) ? 16'd32768 : 16'd0;
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  // Present one item, hold it until accepted, then queue its prediction.
  task automatic send_item(item_t it);
    point_t pt;
    start_i    <= 1'b1;
    op_i       <= it.op;
    corner_i   <= it.corner;
    pos_x_i    <= it.px;  pos_y_i <= it.py;  pos_z_i <= it.pz;
    nrm_x_i    <= it.nx;  nrm_y_i <= it.ny;  nrm_z_i <= it.nz;
    weight_u_i <= it.wu;  weight_v_i <= it.wv;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (tessellate(it, pt)) begin
      if (it.has_lit && (pt.x !== it.ex || pt.y !== it.ey || pt.z !== it.ez)) begin
        $display("%0t: table row expected %h %h %h, predictor %h %h %h", $time,
                 it.ex, it.ey, it.ez, pt.x, pt.y, pt.z);
        fail_count++;
      end
      expected_points.push_back(pt);
    end
  endtask

  // Sender gaps: bursts of random length, with random idle stretches between.
  int burst_left = 0;
  task automatic maybe_idle();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(30);
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(40);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  item_t table_rows[$];

  initial begin
    item_t it;
    int wait_cycles;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset every corner reads as zero.
    table_rows.push_back(lit(eval_item(16'd10923, 16'd10923), '0, '0, '0));
    // Extremes of position with zero normals: the flat point stands.
    table_rows.push_back(load_item(2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                                   16'd0, 16'd0, 16'd0));
    table_rows.push_back(lit(eval_item(16'd32768, 16'd0), 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h0001_0000));
    // Weight above one saturates to one.
    table_rows.push_back(lit(eval_item(16'hFFFF, 16'd0), 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h0001_0000));
    table_rows.push_back(load_item(2'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
                                   16'hC000, 16'h4000, 16'h4000));
    table_rows.push_back(load_item(2'd2, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                                   16'h4000, 16'h0000, 16'hC000));
    // Corner three: the load is dropped.
    table_rows.push_back(load_item(2'd3, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
                                   16'h4000, 16'h4000, 16'h4000));
    table_rows.push_back(eval_item(16'd0, 16'd0));
    table_rows.push_back(eval_item(16'd0, 16'd32768));
    table_rows.push_back(eval_item(16'd32768, 16'd32768));   // weights sum above one
    table_rows.push_back(eval_item(16'hFFFF, 16'hFFFF));
    table_rows.push_back(eval_item(16'd8192, 16'd8192));
    // Non-unit normals, used as given.
    table_rows.push_back(load_item(2'd0, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000,
                                   16'h4000, 16'h4000, 16'hC000));
    table_rows.push_back(load_item(2'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   16'hC000, 16'hC000, 16'hC000));
    table_rows.push_back(eval_item(16'd16384, 16'd16384));
    table_rows.push_back(eval_item(16'd32767, 16'd1));
    table_rows.push_back(eval_item(16'd20000, 16'd30000));

    foreach (table_rows[i]) send_item(table_rows[i]);

    // Random part: mostly full patches followed by several evaluates.
    for (int n = 0; n < 1250; ) begin
      if ($urandom_range(5) != 0) begin
        for (int k = 0; k < 3; k++) begin
          maybe_idle();
          send_item(load_item(k[1:0], rand_position(), rand_position(), rand_position(),
                              rand_normal(), rand_normal(), rand_normal()));
          n++;
        end
        repeat ($urandom_range(1, 4)) begin
          maybe_idle();
          send_item(eval_item(rand_weight(), rand_weight()));
          n++;
        end
      end else begin
        // Noise: a lone load with any corner and any raw normal bits.
        maybe_idle();
        it = load_item(2'($urandom), rand_position(), rand_position(), rand_position(),
                       16'($urandom), 16'($urandom), 16'($urandom));
        send_item(it);
        n++;
      end
    end
    start_i <= 1'b0;

    wait_cycles = 0;
    while (expected_points.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && expected_points.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop: even if every item were an evaluate after the longest sender gap, the run ends far sooner.
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule
